[rtl/core/ndgf_pkg.sv]
// ndgf_pkg: shared types, constants and helpers for the nested delimiter group finder
// no dependencies; imported by ndgf_step, nested_delimiter_group_finder and tb

package ndgf_pkg;

    localparam int POSITION_BITS = 32;
    localparam int DEPTH_BITS    = 16;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 3;

    localparam logic [63:0] POS_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - POSITION_BITS);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    // scan phase codes
    localparam logic [1:0] PH_SEEK  = 2'd0;
    localparam logic [1:0] PH_GROUP = 2'd1;
    localparam logic [1:0] PH_DRAIN = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_OPEN_BYTE   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CLOSE_BYTE  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ESCAPE_BYTE = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ESCAPE_EN   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SKIP_SPACE  = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SCAN_BASE   = 3'd5;

    // ascii whitespace
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0]  open_byte;
        logic [7:0]  close_byte;
        logic [7:0]  escape_byte;
        logic        escape_enable;
        logic        skip_leading_space;
        logic [31:0] scan_base;
    } cfg_t;

    typedef struct packed {
        logic [1:0]               phase;
        logic [DEPTH_BITS-1:0]    nest_depth;
        logic [7:0]               previous_byte;
        logic                     just_opened;
        logic [POSITION_BITS-1:0] byte_position;
        logic [POSITION_BITS-1:0] opener_position;
    } scan_state_t;

    typedef struct packed {
        logic        valid;
        logic        found;
        logic [31:0] open_position;
        logic [31:0] close_position;
    } result_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    // base plus offset, wrapped at the position width, reported as 32 bits
    function automatic logic [31:0] abs_pos(input logic [31:0] base,
                                            input logic [POSITION_BITS-1:0] offset);
        logic [63:0] sum;
        sum = {32'd0, base} + 64'(offset);
        sum = sum & POS_MASK;
        return sum[31:0];
    endfunction

endpackage

[rtl/core/nested_delimiter_group_finder.sv]
// nested_delimiter_group_finder: top level of the delimited group finder
// depends on ndgf_pkg and ndgf_step
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   s_      | in        | s_valid / s_ready    | s_data_byte, s_final_byte
//   m_      | out       | m_valid / m_ready    | m_found, m_open_position, m_close_position
//   cfg_    | in        | cfg_we (no wait)     | cfg_addr, cfg_wdata
//
// one byte per cycle while the output is not stalled: each transaction updates the scan
// state when it is accepted, and its result appears in the output register in the next cycle
// the single output register is the only buffer; s_ready is high whenever it is
// empty or is being emptied, so with m_ready held high the block takes a byte
// every cycle
// aresetn is synchronous and active low; it restores the registers to their
// reset values and drops any pending result
// a stalled result holds the input off until it is taken

module nested_delimiter_group_finder (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [ndgf_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [ndgf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    // byte stream
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_final_byte,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_found,
    output logic [31:0]                         m_open_position,
    output logic [31:0]                         m_close_position
);
    import ndgf_pkg::*;

    cfg_t        cfg_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    result_t     step_res;

    logic        m_valid_reg;
    logic        m_valid_next;
    logic        m_found_reg;
    logic [31:0] m_open_reg;
    logic [31:0] m_close_reg;
    logic        s_accept;

    // output register empty or draining this cycle
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign m_valid          = m_valid_reg;
    assign m_found          = m_found_reg;
    assign m_open_position  = m_open_reg;
    assign m_close_position = m_close_reg;

    // per-byte scan logic
    ndgf_step u_step (
        .cfg        (cfg_reg),
        .cur        (state_reg),
        .data_byte  (s_data_byte),
        .final_byte (s_final_byte),
        .nxt        (state_next),
        .res        (step_res)
    );

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.open_byte          <= 8'd40;
            cfg_reg.close_byte         <= 8'd41;
            cfg_reg.escape_byte        <= 8'd92;
            cfg_reg.escape_enable      <= 1'b0;
            cfg_reg.skip_leading_space <= 1'b0;
            cfg_reg.scan_base          <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_OPEN_BYTE:   cfg_reg.open_byte          <= cfg_wdata[7:0];
                REG_CLOSE_BYTE:  cfg_reg.close_byte         <= cfg_wdata[7:0];
                REG_ESCAPE_BYTE: cfg_reg.escape_byte        <= cfg_wdata[7:0];
                REG_ESCAPE_EN:   cfg_reg.escape_enable      <= cfg_wdata[0];
                REG_SKIP_SPACE:  cfg_reg.skip_leading_space <= cfg_wdata[0];
                REG_SCAN_BASE:   cfg_reg.scan_base          <= cfg_wdata[31:0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // scan state advances once per accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase           <= PH_SEEK;
            state_reg.nest_depth      <= '0;
            state_reg.previous_byte   <= '0;
            state_reg.just_opened     <= 1'b0;
            state_reg.byte_position   <= '0;
            state_reg.opener_position <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // result valid: loaded on accept, cleared when taken
    always_comb begin
        if (s_accept) begin
            m_valid_next = step_res.valid;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept && step_res.valid) begin
            m_found_reg <= step_res.found;
            m_open_reg  <= step_res.open_position;
            m_close_reg <= step_res.close_position;
        end
    end

    // a failed scan reports zero positions
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_open_reg == '0 && m_close_reg == '0))
        else $error("failure result with nonzero position");

    // inside a group the depth never reaches zero
    a_group_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_GROUP) |-> (state_reg.nest_depth != '0))
        else $error("group phase with zero depth");

    // seeking an opener always starts from a clean depth with the just-opened flag clear
    a_seek_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_SEEK) |-> (state_reg.nest_depth == '0 &&
                                          !state_reg.just_opened))
        else $error("seek phase with stale group state");

    // back-pressure only while a result is pending, and that result stays
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> m_valid_reg)
        else $error("pending result lost during stall");

endmodule

[rtl/core/ndgf_step.sv]
// ndgf_step: per-byte next-state and result logic of the group finder
// depends on ndgf_pkg

module ndgf_step (
    input  ndgf_pkg::cfg_t        cfg,
    input  ndgf_pkg::scan_state_t cur,
    input  logic [7:0]            data_byte,
    input  logic                  final_byte,
    output ndgf_pkg::scan_state_t nxt,
    output ndgf_pkg::result_t     res
);
    import ndgf_pkg::*;

    logic                  escaped;
    logic                  closed;
    logic [DEPTH_BITS-1:0] depth_dec;

    always_comb begin
        nxt       = cur;
        res       = '0;
        closed    = 1'b0;
        escaped   = cfg.escape_enable && !cur.just_opened &&
                    (cur.previous_byte == cfg.escape_byte);
        depth_dec = (cur.nest_depth != '0) ? cur.nest_depth - 1'b1 : cur.nest_depth;

        case (cur.phase)
            PH_SEEK: begin
                if (cfg.skip_leading_space && is_space(data_byte)) begin
                    res.valid = final_byte;
                end else if (data_byte == cfg.open_byte) begin
                    nxt.opener_position = cur.byte_position;
                    nxt.nest_depth      = DEPTH_BITS'(1);
                    nxt.just_opened     = 1'b1;
                    nxt.previous_byte   = data_byte;
                    nxt.phase           = PH_GROUP;
                    res.valid           = final_byte;
                end else begin
                    res.valid = 1'b1;
                    nxt.phase = PH_DRAIN;
                end
            end
            PH_GROUP: begin
                if (!escaped) begin
                    if (cfg.open_byte == cfg.close_byte) begin
                        closed = (data_byte == cfg.close_byte);
                    end else if (data_byte == cfg.open_byte) begin
                        if (cur.nest_depth != DEPTH_MAX) begin
                            nxt.nest_depth = cur.nest_depth + 1'b1;
                        end
                    end else if (data_byte == cfg.close_byte) begin
                        nxt.nest_depth = depth_dec;
                        closed         = (depth_dec == '0);
                    end
                end
                nxt.just_opened   = 1'b0;
                nxt.previous_byte = data_byte;
                if (closed) begin
                    res.valid          = 1'b1;
                    res.found          = 1'b1;
                    res.open_position  = abs_pos(cfg.scan_base, cur.opener_position);
                    res.close_position = abs_pos(cfg.scan_base, cur.byte_position);
                    nxt.phase          = PH_DRAIN;
                end else begin
                    res.valid = final_byte;
                end
            end
            default: begin
                // draining the rest of the scan
            end
        endcase

        if (final_byte) begin
            nxt.phase         = PH_SEEK;
            nxt.byte_position = '0;
            nxt.nest_depth    = '0;
            nxt.previous_byte = '0;
            nxt.just_opened   = 1'b0;
        end else begin
            nxt.byte_position = cur.byte_position + 1'b1;
        end
    end

endmodule

[test/tb.sv]
// tb: self-checking testbench for nested_delimiter_group_finder
// depends on ndgf_pkg and the rtl; tracks scan state alongside the block and checks
// every result transaction field by field, under random idling on both channels
`timescale 1ns / 1ps

module tb;
    import ndgf_pkg::*;

    localparam int QUIET_LIMIT     = 4000;  // cycles with no transaction before giving up
    localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall in the backpressure test
    localparam int SETTLE_CYCLES   = 4;     // quiet cycles waited after the last owed result
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_BYTES     = 150;
    localparam int NEST_LEVELS     = 40;    // nesting depth in the deep nesting test

    typedef struct packed {
        logic        found;
        logic [31:0] open_position;
        logic [31:0] close_position;
    } group_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_final_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_found;
    logic [31:0] m_open_position;
    logic [31:0] m_close_position;

    nested_delimiter_group_finder dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_final_byte     (s_final_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .m_open_position  (m_open_position),
        .m_close_position (m_close_position)
    );

    // results still owed by the block, oldest first
    group_result_t expected_groups[$];
    int            bad_results;

    // idling knobs: percent of transactions that get a random wait
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic hold_off_req;

    // bytes of the scan being built
    logic [7:0] scan_bytes[$];

    // shadow of the configuration registers and of the scan state
    cfg_t                    live_cfg;
    logic [1:0]              scan_phase;
    logic [DEPTH_BITS-1:0]   nest_level;
    logic [7:0]              last_byte;
    logic                    fresh_open;
    logic [POSITION_BITS-1:0] scan_offset;
    logic [POSITION_BITS-1:0] opener_offset;

    // 4 ns clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // clear the scan state, as after a final byte
    task automatic restart_scan();
        scan_phase  = PH_SEEK;
        scan_offset = '0;
        nest_level  = '0;
        last_byte   = 8'h00;
        fresh_open  = 1'b0;
    endtask

    // work out what one accepted byte does to the scan and queue any result
    task automatic track_group_scan(input logic [7:0] b, input logic fin);
        logic [POSITION_BITS-1:0] here;
        logic          escaped;
        logic          closed;
        logic          emit;
        logic          ok;
        group_result_t res;
        here   = scan_offset;
        closed = 1'b0;
        emit   = 1'b0;
        ok     = 1'b0;
        case (scan_phase)
            PH_SEEK: begin
                if (live_cfg.skip_leading_space
                        && (b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})) begin
                    // leading whitespace only fails when the scan ends on it
                    emit = fin;
                end else if (b == live_cfg.open_byte) begin
                    opener_offset = here;
                    nest_level    = DEPTH_BITS'(1);
                    fresh_open    = 1'b1;
                    last_byte     = b;
                    scan_phase    = PH_GROUP;
                    emit          = fin;
                end else begin
                    // anything else before the opener fails the scan at once
                    emit       = 1'b1;
                    scan_phase = PH_DRAIN;
                end
            end
            PH_GROUP: begin
                // the byte right after the opener is never escaped
                escaped = live_cfg.escape_enable && !fresh_open
                          && (last_byte == live_cfg.escape_byte);
                if (!escaped) begin
                    if (live_cfg.open_byte == live_cfg.close_byte) begin
                        closed = (b == live_cfg.close_byte);
                    end else if (b == live_cfg.open_byte) begin
                        if (nest_level != DEPTH_MAX) nest_level = nest_level + 1'b1;
                    end else if (b == live_cfg.close_byte) begin
                        if (nest_level != 0) nest_level = nest_level - 1'b1;
                        closed = (nest_level == 0);
                    end
                end
                fresh_open = 1'b0;
                last_byte  = b;
                if (closed) begin
                    emit       = 1'b1;
                    ok         = 1'b1;
                    scan_phase = PH_DRAIN;
                end else begin
                    emit = fin;
                end
            end
            default: ;  // draining: bytes up to the final one are swallowed
        endcase
        if (emit) begin
            res.found          = ok;
            res.open_position  = ok ? 32'(live_cfg.scan_base + opener_offset) : 32'd0;
            res.close_position = ok ? 32'(live_cfg.scan_base + here) : 32'd0;
            expected_groups.push_back(res);
        end
        if (fin) restart_scan();
        else scan_offset = scan_offset + 1'b1;
    endtask

    // register write; the block is idle whenever this is called
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_OPEN_BYTE:   live_cfg.open_byte          = val[7:0];
            REG_CLOSE_BYTE:  live_cfg.close_byte         = val[7:0];
            REG_ESCAPE_BYTE: live_cfg.escape_byte        = val[7:0];
            REG_ESCAPE_EN:   live_cfg.escape_enable      = val[0];
            REG_SKIP_SPACE:  live_cfg.skip_leading_space = val[0];
            REG_SCAN_BASE:   live_cfg.scan_base          = val;
            default: ;
        endcase
    endtask

    // one byte transaction on the input channel; valid stays up until accepted
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(0, 19) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid      = 1'b1;
        s_data_byte  = b;
        s_final_byte = fin;
        do @(posedge aclk); while (!s_ready);
        track_group_scan(b, fin);
    endtask

    // send the built scan, final flag on its last byte
    task automatic send_scan();
        foreach (scan_bytes[i]) send_byte(scan_bytes[i], i == scan_bytes.size() - 1);
    endtask

    task automatic load_text(input string txt);
        scan_bytes.delete();
        for (int i = 0; i < txt.len(); i++) scan_bytes.push_back(txt[i]);
    endtask

    // drop valid, then wait for every owed result and then wait out the settle time
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_groups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly well-formed groups with random content, some noise up front
    task automatic build_random_scan();
        int kind;
        int pick;
        scan_bytes.delete();
        kind = $urandom_range(0, 99);
        if (live_cfg.skip_leading_space) begin
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 3))
                    0: scan_bytes.push_back(CH_SPACE);
                    1: scan_bytes.push_back(CH_TAB);
                    2: scan_bytes.push_back(CH_LF);
                    default: scan_bytes.push_back(CH_CR);
                endcase
            end
        end
        if (kind < 10) begin
            repeat ($urandom_range(1, 6)) scan_bytes.push_back(8'($urandom));
        end else begin
            scan_bytes.push_back(live_cfg.open_byte);
            repeat ($urandom_range(0, 14)) begin
                pick = $urandom_range(0, 99);
                if (pick < 25)      scan_bytes.push_back(live_cfg.open_byte);
                else if (pick < 60) scan_bytes.push_back(live_cfg.close_byte);
                else if (pick < 75) scan_bytes.push_back(live_cfg.escape_byte);
                else                scan_bytes.push_back(8'($urandom));
            end
            // usually pile on closers so most groups actually close
            if (kind < 85) repeat ($urandom_range(0, 4)) scan_bytes.push_back(live_cfg.close_byte);
            repeat ($urandom_range(0, 3)) scan_bytes.push_back(8'($urandom));
        end
    endtask

    // ---------------------------------------------------------------- tests

    // reset values: parentheses, no escape, no whitespace skip, base zero
    task automatic test_defaults();
        load_text("((a)b)"); send_scan();   // nested group
        load_text("x");      send_scan();   // wrong first byte
        load_text("(");      send_scan();   // ends without close
        load_text("()z");    send_scan();   // trailing bytes drained
        wait_for_drain();
    endtask

    task automatic test_skip_space();
        write_reg(REG_SKIP_SPACE, 32'd1);
        load_text(" \t\n\r()"); send_scan();
        load_text(" ");         send_scan();  // scan ends on whitespace
        wait_for_drain();
        write_reg(REG_SKIP_SPACE, 32'd0);
    endtask

    task automatic test_escape();
        write_reg(REG_ESCAPE_EN, 32'd1);
        load_text("(\\))"); send_scan();       // escaped closer is ignored
        wait_for_drain();
        write_reg(REG_ESCAPE_EN, 32'd0);
    endtask

    task automatic test_same_delimiters();
        write_reg(REG_OPEN_BYTE, 32'h22);
        write_reg(REG_CLOSE_BYTE, 32'h22);
        load_text("\"a\""); send_scan();       // first closer ends the group
        wait_for_drain();
    endtask

    // base plus offset wraps past the top of the position range
    task automatic test_position_wrap();
        write_reg(REG_OPEN_BYTE, 32'h28);
        write_reg(REG_CLOSE_BYTE, 32'h29);
        write_reg(REG_SCAN_BASE, 32'hFFFF_FFFF);
        load_text("()"); send_scan();
        wait_for_drain();
        write_reg(REG_SCAN_BASE, 32'd0);
    endtask

    task automatic test_byte_extremes();
        write_reg(REG_OPEN_BYTE, 32'h00);
        write_reg(REG_CLOSE_BYTE, 32'hFF);
        write_reg(REG_ESCAPE_BYTE, 32'hFF);
        scan_bytes = '{8'h00, 8'hFF};
        send_scan();
        wait_for_drain();
    endtask

    // nest many levels deep back to back, the group closes on the last byte
    task automatic test_deep_nesting();
        write_reg(REG_OPEN_BYTE, 32'h28);
        write_reg(REG_CLOSE_BYTE, 32'h29);
        write_reg(REG_ESCAPE_EN, 32'd0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (NEST_LEVELS) send_byte(8'h28, 1'b0);
        for (int i = 1; i <= NEST_LEVELS; i++) send_byte(8'h29, i == NEST_LEVELS);
        wait_for_drain();
    endtask

    // receiver stalls for a long stretch while bytes keep coming
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        hold_off_req = 1'b1;
        repeat (6) begin
            load_text("(a)");
            send_scan();
        end
        wait_for_drain();
    endtask

    // random settings per phase, extremes included, random scans in between
    task automatic test_random_scans();
        int sent;
        logic [7:0]  ob;
        logic [7:0]  cb;
        logic [7:0]  eb;
        logic [31:0] base;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0: ob = 8'h28;
                1: ob = 8'h00;
                2: ob = 8'hFF;
                3: ob = 8'h5B;
                default: ob = 8'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: cb = 8'h29;
                1: cb = ob;
                2: cb = 8'hFF;
                3: cb = 8'h00;
                default: cb = 8'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: eb = 8'h5C;
                1: eb = ob;        // escape equal to the opener
                2: eb = cb;
                default: eb = 8'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: base = 32'd0;
                1: base = 32'hFFFF_FFFF;
                2: base = 32'hFFFF_FFF0;
                default: base = $urandom;
            endcase
            write_reg(REG_OPEN_BYTE, {24'd0, ob});
            write_reg(REG_CLOSE_BYTE, {24'd0, cb});
            write_reg(REG_ESCAPE_BYTE, {24'd0, eb});
            write_reg(REG_ESCAPE_EN, 32'($urandom_range(0, 1)));
            write_reg(REG_SKIP_SPACE, 32'($urandom_range(0, 1)));
            write_reg(REG_SCAN_BASE, base);
            // phases rotate the sender idling through none, some and lots
            case (ph % 3)
                0: tx_idle_pct = 0;
                1: tx_idle_pct = 30;
                default: tx_idle_pct = 100;
            endcase
            case ($urandom_range(0, 2))
                0: rx_idle_pct = 0;
                1: rx_idle_pct = 30;
                default: rx_idle_pct = 100;
            endcase
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_random_scan();
                send_scan();
                sent += scan_bytes.size();
            end
            wait_for_drain();
        end
    endtask

    // ---------------------------------------------------------------- checker

    // compare every result transaction with the oldest owed result
    always @(posedge aclk) begin : result_check
        group_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_groups.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("%0t: unexpected result found=%0b open=%h close=%h",
                             $realtime, m_found, m_open_position, m_close_position);
            end else begin
                want = expected_groups.pop_front();
                if (m_found !== want.found || m_open_position !== want.open_position
                        || m_close_position !== want.close_position) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display({"%0t: result mismatch exp found=%0b open=%h close=%h,",
                                  " got found=%0b open=%h close=%h"},
                                 $realtime, want.found, want.open_position,
                                 want.close_position,
                                 m_found, m_open_position, m_close_position);
                end
            end
        end
    end

    // result side: random stall after each transaction, plus the long hold-off
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            m_ready = (stall_left == 0);
            if (stall_left > 0) stall_left--;
            @(posedge aclk);
            if (m_valid && m_ready)
                stall_left = ($urandom_range(0, 99) < rx_idle_pct) ? $urandom_range(0, 19) : 0;
        end
    end

    // watchdog: too long without any transaction means the block is stuck
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_data_byte  = 8'h00;
        s_final_byte = 1'b0;
        hold_off_req = 1'b0;
        tx_idle_pct  = 30;
        rx_idle_pct  = 30;
        bad_results  = 0;
        // register reset values: '(' ')' '\' , features off, base zero
        live_cfg.open_byte          = 8'h28;
        live_cfg.close_byte         = 8'h29;
        live_cfg.escape_byte        = 8'h5C;
        live_cfg.escape_enable      = 1'b0;
        live_cfg.skip_leading_space = 1'b0;
        live_cfg.scan_base          = 32'd0;
        opener_offset               = '0;
        restart_scan();
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_defaults();
        test_skip_space();
        test_escape();
        test_same_delimiters();
        test_position_wrap();
        test_byte_extremes();
        test_deep_nesting();
        test_backpressure();
        test_random_scans();

        wait_for_drain();
        repeat (10) @(posedge aclk);
        if (bad_results == 0 && expected_groups.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
